>>> sv/sblc_pkg.sv
// ----------------------------------------------------------------------------
// sblc_pkg
// Shared types and constants of the size-budget LRU cache tracker.
// ----------------------------------------------------------------------------
package sblc_pkg;

  localparam int unsigned SLOTS_DEF    = 32;
  localparam int unsigned KEY_BITS_DEF = 32;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned KIND_W       = 3;
  localparam logic [31:0] BUDGET_RST   = 32'd1048576;

  localparam logic [KIND_W-1:0] KIND_EVICT     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FETCH     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_HIT       = 3'd2;
  localparam logic [KIND_W-1:0] KIND_MISMATCH  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_TOO_LARGE = 3'd4;

  localparam logic REG_BUDGET = 1'b0;

  // input beat
  typedef struct packed {
    logic [31:0] item_id;
    logic [31:0] item_size;
  } access_t;

  // result beat
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [31:0]       result_id;
    logic              last;
    logic [31:0]       evict_total;
    logic [31:0]       fetch_total;
  } beat_t;

  // datapath commands
  typedef struct packed {
    logic load;      // capture the input beat
    logic scan;      // one slot of the search pass
    logic scan_clr;  // restart the scan pointer
    logic touch;     // move the hit slot to most recent
    logic evict;     // remove the oldest slot
    logic insert;    // place the new item
    logic emit;      // load the output register
    logic [KIND_W-1:0] kind;
    logic last;
  } cmd_t;

  // datapath status
  typedef struct packed {
    logic scan_done;
    logic hit;
    logic size_eq;
    logic too_large;
    logic need_evict;
    logic out_full;
  } sts_t;

endpackage

>>> sv/sblc_if.sv
// ----------------------------------------------------------------------------
// sblc_if
// Valid/ready channel carrying a payload of parameterised type.
// ----------------------------------------------------------------------------
interface sblc_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> sv/sblc_ram.sv
// ----------------------------------------------------------------------------
// sblc_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module sblc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata <= mem_r[addr];
  end
endmodule

>>> sv/sblc_datapath.sv
// ----------------------------------------------------------------------------
// sblc_datapath
// Slot store, recency ranks, byte and event counters, output register.
// ----------------------------------------------------------------------------
module sblc_datapath #(
  parameter int unsigned SLOTS    = sblc_pkg::SLOTS_DEF,
  parameter int unsigned KEY_BITS = sblc_pkg::KEY_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sblc_pkg::cmd_t       cmd,
  output sblc_pkg::sts_t       sts,
  input  logic [31:0]          budget,
  input  logic [31:0]          in_id,
  input  logic [31:0]          in_size,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [2:0]           out_kind,
  output logic [31:0]          out_id,
  output logic                 out_last,
  output logic [31:0]          out_evict,
  output logic [31:0]          out_fetch
);
  localparam int unsigned IW = $clog2(SLOTS);
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam int unsigned KW = (KEY_BITS < 32) ? KEY_BITS : 32;

  logic [SLOTS-1:0] valid_r, valid_nxt;
  logic [IW-1:0]    rank_r [SLOTS];
  logic [KW-1:0]    key_r [SLOTS];
  logic [CW-1:0]    cnt_r;
  logic [31:0]      used_r, evict_r, fetch_r;
  logic [KW-1:0]    id_r;
  logic [31:0]      size_r;
  logic [IW-1:0]    ptr_r, hit_slot_r, old_slot_r;
  logic [CW-1:0]    ptr_cnt_r;
  logic             hit_r;
  logic             ov_r;
  logic [2:0]       kind_r;
  logic [31:0]      rid_r;
  logic             last_r;

  // byte sizes live in RAM; key/rank stay in flops for rank renumbering
  logic            ram_we;
  logic [IW-1:0]   ram_addr;
  logic [31:0]     ram_rd;
  logic [IW-1:0]   free_slot;
  logic            free_found;
  logic [IW-1:0]   target;

  always_comb begin
    free_slot  = '0;
    free_found = 1'b0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_slot  = IW'(i);
        free_found = 1'b1;
      end
    end
  end

  assign ram_we   = cmd.insert && free_found;
  assign ram_addr = cmd.insert ? free_slot : (hit_r ? hit_slot_r : old_slot_r);

  sblc_ram #(.WIDTH(32), .DEPTH(1 << IW)) u_bytes (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(size_r),
    .rdata(ram_rd)
  );

  assign target = hit_r ? hit_slot_r : old_slot_r;

  logic [32:0] sum;
  assign sum = {1'b0, used_r} + {1'b0, size_r};

  assign sts.scan_done  = (ptr_cnt_r == CW'(SLOTS));
  assign sts.hit        = hit_r;
  assign sts.size_eq    = (ram_rd == size_r);
  assign sts.too_large  = (size_r > budget);
  assign sts.need_evict = (cnt_r != '0) &&
                          ((sum > {1'b0, budget}) || (cnt_r == CW'(SLOTS)));
  assign sts.out_full   = ov_r && !out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      id_r   <= in_id[KW-1:0];
      size_r <= in_size;
    end
    if (cmd.scan_clr || cmd.load) begin
      ptr_r     <= '0;
      ptr_cnt_r <= '0;
    end else if (cmd.scan) begin
      if (valid_r[ptr_r] && key_r[ptr_r] == id_r) begin
        hit_slot_r <= ptr_r;
      end
      if (valid_r[ptr_r] && rank_r[ptr_r] == '0) begin
        old_slot_r <= ptr_r;
      end
      ptr_r     <= (ptr_cnt_r == CW'(SLOTS - 1)) ? ptr_r : ptr_r + 1'b1;
      ptr_cnt_r <= ptr_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (cmd.load) begin
      hit_r <= 1'b0;
    end else if (cmd.scan && valid_r[ptr_r] && key_r[ptr_r] == id_r) begin
      hit_r <= 1'b1;
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (cmd.evict) valid_nxt[old_slot_r] = 1'b0;
    if (cmd.insert && free_found) valid_nxt[free_slot] = 1'b1;
  end

  // rank renumbering is per-slot independent logic
  always_ff @(posedge clk) begin
    for (int i = 0; i < SLOTS; i++) begin
      if ((cmd.touch || cmd.evict) && valid_r[i] && IW'(i) != target &&
          rank_r[i] > rank_r[target]) begin
        rank_r[i] <= rank_r[i] - 1'b1;
      end
    end
    if (cmd.touch) rank_r[hit_slot_r] <= IW'(cnt_r - 1'b1);
    if (cmd.insert && free_found) begin
      rank_r[free_slot] <= IW'(cnt_r);
      key_r[free_slot]  <= id_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      cnt_r   <= '0;
      used_r  <= '0;
      evict_r <= '0;
      fetch_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (cmd.evict) begin
        cnt_r   <= cnt_r - 1'b1;
        used_r  <= (ram_rd > used_r) ? '0 : used_r - ram_rd;
        evict_r <= evict_r + 1'b1;
      end
      if (cmd.insert) begin
        fetch_r <= fetch_r + 1'b1;
        if (free_found) begin
          cnt_r  <= cnt_r + 1'b1;
          used_r <= sum[31:0];
        end
      end
      if (cmd.emit) begin
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  // the output beat carries the counters after the event
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      kind_r <= cmd.kind;
      last_r <= cmd.last;
      rid_r  <= cmd.evict ? 32'(key_r[old_slot_r]) : 32'(id_r);
    end
  end

  logic [31:0] evict_out_r, fetch_out_r;
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      evict_out_r <= cmd.evict ? evict_r + 1'b1 : evict_r;
      fetch_out_r <= cmd.insert ? fetch_r + 1'b1 : fetch_r;
    end
  end

  assign out_valid = ov_r;
  assign out_kind  = kind_r;
  assign out_id    = rid_r;
  assign out_last  = last_r;
  assign out_evict = evict_out_r;
  assign out_fetch = fetch_out_r;
endmodule

>>> sv/sblc_ctrl.sv
// ----------------------------------------------------------------------------
// sblc_ctrl
// Access sequencer: search pass, hit handling, eviction loop, fetch.
// ----------------------------------------------------------------------------
module sblc_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  sblc_pkg::sts_t sts,
  output sblc_pkg::cmd_t cmd
);
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_DEC   = 3'd3;
  localparam logic [2:0] ST_EVICT = 3'd4;

  logic [2:0] state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE) && !sts.out_full;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = ST_READ;
        end else begin
          cmd.scan = 1'b1;
        end
      end
      // wait state for the registered byte read
      ST_READ: state_nxt = ST_DEC;
      ST_DEC: begin
        if (!sts.out_full) begin
          cmd.emit = 1'b1;
          cmd.last = 1'b1;
          state_nxt = ST_IDLE;
          if (sts.hit) begin
            if (sts.size_eq) begin
              cmd.kind  = sblc_pkg::KIND_HIT;
              cmd.touch = 1'b1;
            end else begin
              cmd.kind = sblc_pkg::KIND_MISMATCH;
            end
          end else if (sts.too_large) begin
            cmd.kind = sblc_pkg::KIND_TOO_LARGE;
          end else if (sts.need_evict) begin
            cmd.kind  = sblc_pkg::KIND_EVICT;
            cmd.last  = 1'b0;
            cmd.evict = 1'b1;
            state_nxt = ST_EVICT;
          end else begin
            cmd.kind   = sblc_pkg::KIND_FETCH;
            cmd.insert = 1'b1;
          end
        end
      end
      // rescan to find the new oldest slot
      ST_EVICT: begin
        cmd.scan_clr = 1'b1;
        state_nxt    = ST_SCAN;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule

>>> sv/size_budget_lru_cache_unit.sv
// ----------------------------------------------------------------------------
// size_budget_lru_cache_unit
// Size-aware LRU residency tracker with a byte budget.
// ----------------------------------------------------------------------------
// in_ channel: one beat per access (item_id, item_size).
// out_ channel: one or more beats per access; evictions in LRU order, then
//   a closing beat (fetch, hit, mismatch or too large) with last set.
// cfg_ port: APB-style, register 0 at address 0 is byte_budget.
// Sequence: a sequential search pass over all slots, a step to close it,
//   the registered byte read and a decision step that loads the first beat;
//   after each eviction beat a clear step and a fresh pass follow before
//   the next beat is loaded.
// One access is handled at a time; in_ready is low while one is in flight
//   and rises once the sequencer is back in idle after the closing beat is
//   loaded and the output register is not held by a stalled receiver.
// The output register holds a beat while the receiver stalls and the
//   sequencer waits on it, so no beat is lost; in_ready stays low meanwhile.
// Reset clears slots, counters and the budget to its default; no clearing
//   pass is needed.
// ----------------------------------------------------------------------------
module size_budget_lru_cache_unit #(
  parameter int unsigned SLOTS    = sblc_pkg::SLOTS_DEF,
  parameter int unsigned KEY_BITS = sblc_pkg::KEY_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  sblc_if.sink        in_ch,
  sblc_if.source      out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  sblc_pkg::cmd_t cmd;
  sblc_pkg::sts_t sts;
  logic [31:0]    budget_r;
  logic           reg_hit;

  assign cfg_pready = 1'b1;
  assign reg_hit    = (cfg_paddr[1:0] == 2'b00) &&
                      (1'b0 == sblc_pkg::REG_BUDGET);
  assign cfg_prdata = reg_hit ? budget_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_r <= sblc_pkg::BUDGET_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && reg_hit) begin
      budget_r <= cfg_pwdata;
    end
  end

  sblc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .sts(sts), .cmd(cmd)
  );

  sblc_datapath #(.SLOTS(SLOTS), .KEY_BITS(KEY_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .budget(budget_r),
    .in_id(in_ch.data.item_id), .in_size(in_ch.data.item_size),
    .out_ready(out_ch.ready), .out_valid(out_ch.valid),
    .out_kind(out_ch.data.kind), .out_id(out_ch.data.result_id),
    .out_last(out_ch.data.last), .out_evict(out_ch.data.evict_total),
    .out_fetch(out_ch.data.fetch_total)
  );

`ifndef SYNTHESIS
  a_no_emit_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    sts.out_full |-> !cmd.emit) else $error("beat overwritten");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> !in_ch.ready) else $error("second access accepted");
  a_evict_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.data.kind == sblc_pkg::KIND_EVICT) |->
    !out_ch.data.last) else $error("eviction closed access");
`endif
endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the size-budget LRU cache tracker. Accesses are
// driven over the in_ channel; directed rows carry their expected beat and a
// built-in predictor of residency, recency and the byte budget builds the
// other expected beats, which are compared in order with what leaves the
// out_ channel. The budget changes between phases over the APB-style port.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NSLOT = sblc_pkg::SLOTS_DEF;
  localparam int unsigned PASS_CYC = NSLOT + 3;
  localparam longint unsigned CYCLE_LIMIT = 2000000;

  typedef struct {
    logic [31:0]                 id;
    logic [31:0]                 size;
    bit                          typed;
    logic [sblc_pkg::KIND_W-1:0] kind;
    logic [31:0]                 ev_tot;
    logic [31:0]                 fe_tot;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic        cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [1:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  sblc_if #(.payload_t(sblc_pkg::access_t)) in_ch ();
  sblc_if #(.payload_t(sblc_pkg::beat_t))   out_ch ();

  size_budget_lru_cache_unit dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata), .cfg_pready(cfg_pready)
  );

  always #6 clk = ~clk;

  // predictor state
  bit          slot_live[NSLOT];
  logic [31:0] slot_id[NSLOT];
  logic [31:0] slot_size[NSLOT];
  int unsigned slot_rank[NSLOT];
  logic [31:0] budget, bytes_used, evict_cnt, fetch_cnt;

  sblc_pkg::beat_t pending_beats[$];
  int          idle_mode = 2;
  int unsigned errors = 0, beats_seen = 0, evicts_seen = 0;
  longint unsigned cycles = 0;

  function automatic int unsigned live_count();
    int unsigned n = 0;
    for (int i = 0; i < NSLOT; i++) if (slot_live[i]) n++;
    return n;
  endfunction

  function automatic void drop_rank(int s);
    for (int i = 0; i < NSLOT; i++)
      if (slot_live[i] && i != s && slot_rank[i] > slot_rank[s]) slot_rank[i]--;
  endfunction

  function automatic void cache_access(logic [31:0] id, logic [31:0] sz,
                                       ref sblc_pkg::beat_t res[$]);
    int hit_slot = -1;
    int victim, free_slot;
    int unsigned n;
    for (int i = 0; i < NSLOT; i++)
      if (slot_live[i] && slot_id[i] == id) hit_slot = i;
    if (hit_slot >= 0) begin
      if (slot_size[hit_slot] != sz) begin
        res.push_back('{sblc_pkg::KIND_MISMATCH, id, 1'b1, evict_cnt, fetch_cnt});
        return;
      end
      n = live_count();
      drop_rank(hit_slot);
      slot_rank[hit_slot] = n - 1;
      res.push_back('{sblc_pkg::KIND_HIT, id, 1'b1, evict_cnt, fetch_cnt});
      return;
    end
    if (sz > budget) begin
      res.push_back('{sblc_pkg::KIND_TOO_LARGE, id, 1'b1, evict_cnt, fetch_cnt});
      return;
    end
    forever begin
      n = live_count();
      if ((({32'd0, bytes_used} + {32'd0, sz}) <= {32'd0, budget}) && n < NSLOT) break;
      if (n == 0) break;
      victim = -1;
      for (int i = 0; i < NSLOT; i++)
        if (slot_live[i] && slot_rank[i] == 0) victim = i;
      if (victim < 0) break;
      drop_rank(victim);
      slot_live[victim] = 1'b0;
      bytes_used = (slot_size[victim] > bytes_used) ? 32'd0
                                                    : bytes_used - slot_size[victim];
      evict_cnt++;
      res.push_back('{sblc_pkg::KIND_EVICT, slot_id[victim], 1'b0, evict_cnt,
                      fetch_cnt});
    end
    free_slot = -1;
    for (int i = NSLOT - 1; i >= 0; i--) if (!slot_live[i]) free_slot = i;
    if (free_slot >= 0) begin
      n = live_count();
      slot_live[free_slot] = 1'b1;
      slot_id[free_slot] = id;
      slot_size[free_slot] = sz;
      slot_rank[free_slot] = n;
      bytes_used += sz;
    end
    fetch_cnt++;
    res.push_back('{sblc_pkg::KIND_FETCH, id, 1'b1, evict_cnt, fetch_cnt});
  endfunction

  // caller sits at a falling edge; returns at a falling edge with valid high
  task automatic send_access(row_t r);
    sblc_pkg::beat_t res[$];
    int idle_pct;
    idle_pct = (idle_mode == 0) ? 11 : (idle_mode == 1) ? 68 : 0;
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= '{r.id, r.size};
    do @(posedge clk); while (!in_ch.ready);
    cache_access(r.id, r.size, res);
    if (r.typed)
      pending_beats.push_back('{r.kind, r.id, 1'b1, r.ev_tot, r.fe_tot});
    else
      foreach (res[i]) pending_beats.push_back(res[i]);
    @(negedge clk);
  endtask

  task automatic set_budget(logic [31:0] value);
    in_ch.valid <= 1'b0;
    wait (pending_beats.size() == 0);
    @(negedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_paddr <= 2'(sblc_pkg::REG_BUDGET);
    cfg_pwdata <= value;
    @(negedge clk) cfg_penable <= 1'b1;
    @(negedge clk) begin
      cfg_pwrite <= 1'b0; cfg_penable <= 1'b0;
    end
    @(negedge clk) cfg_penable <= 1'b1;
    @(posedge clk);
    if (cfg_prdata !== value || cfg_pready !== 1'b1) begin
      $display("%0t budget readback: expected %h actual %h", $realtime, value, cfg_prdata);
      errors++;
    end
    @(negedge clk) begin
      cfg_psel <= 1'b0; cfg_penable <= 1'b0;
    end
    budget = value;
  endtask

  // receiver
  always @(negedge clk) begin
    case (idle_mode)
      0: out_ch.ready <= ($urandom_range(99) >= 68);
      1: out_ch.ready <= ($urandom_range(99) >= 11);
      default: out_ch.ready <= 1'b1;
    endcase
  end

  always @(posedge clk) begin
    sblc_pkg::beat_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      beats_seen++;
      if (out_ch.data.kind == sblc_pkg::KIND_EVICT) evicts_seen++;
      if (pending_beats.size() == 0) begin
        $display("%0t unexpected beat: actual %p", $realtime, out_ch.data);
        errors++;
      end else begin
        want = pending_beats[0];
        pending_beats.delete(0);
        if (out_ch.data !== want) begin
          $display("%0t beat mismatch: expected %p actual %p",
                   $realtime, want, out_ch.data);
          errors++;
        end
      end
    end
  end

  row_t directed[] = '{
    '{32'h0000_0000, 32'h0000_0000, 1, sblc_pkg::KIND_FETCH,     32'd0, 32'd1},
    '{32'hFFFF_FFFF, 32'h0000_0100, 1, sblc_pkg::KIND_FETCH,     32'd0, 32'd2},
    '{32'h0000_0000, 32'h0000_0000, 1, sblc_pkg::KIND_HIT,       32'd0, 32'd2},
    '{32'h0000_0000, 32'h0000_0005, 1, sblc_pkg::KIND_MISMATCH,  32'd0, 32'd2},
    '{32'h0000_0007, 32'hFFFF_FFFF, 1, sblc_pkg::KIND_TOO_LARGE, 32'd0, 32'd2},
    '{32'hFFFF_FFFF, 32'h0000_0100, 1, sblc_pkg::KIND_HIT,       32'd0, 32'd2},
    '{32'hAAAA_5555, 32'h0000_8000, 0, '0, '0, '0},
    '{32'h5555_AAAA, 32'h0001_0000, 0, '0, '0, '0},
    '{32'h0000_0000, 32'h0000_0000, 0, '0, '0, '0},
    '{32'h1234_5678, 32'h0010_0000, 0, '0, '0, '0},
    '{32'h8000_0001, 32'h0000_0001, 0, '0, '0, '0},
    '{32'h1234_5678, 32'h0010_0000, 0, '0, '0, '0},
    '{32'h0000_0000, 32'h0000_0000, 0, '0, '0, '0},
    '{32'h7FFF_FFFE, 32'h0010_0001, 0, '0, '0, '0}
  };

  logic [31:0] phase_budget[5] = '{32'd4096, 32'd0, 32'hFFFF_FFFF, 32'd1500, 32'd1048576};
  int          phase_items[5]  = '{36, 10, 25, 22, 23};

  initial begin
    logic [31:0] key_pool[40], size_pool[40];
    row_t r;
    int k, sent;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    out_ch.ready = 1'b0;
    for (int i = 0; i < NSLOT; i++) begin
      slot_live[i] = 1'b0; slot_id[i] = '0; slot_size[i] = '0; slot_rank[i] = 0;
    end
    budget = sblc_pkg::BUDGET_RST; bytes_used = '0; evict_cnt = '0; fetch_cnt = '0;
    for (int i = 0; i < 40; i++) begin
      key_pool[i]  = (i < 4) ? $urandom() : 32'(i * 32'h0101_0101);
      size_pool[i] = $urandom_range(0, 1200);
    end
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed[i]) send_access(directed[i]);

    sent = 0;
    for (int p = 0; p < 5; p++) begin
      set_budget(phase_budget[p]);
      for (int j = 0; j < phase_items[p]; j++) begin
        idle_mode = (sent < 39) ? 0 : (sent < 78) ? 1 : 2;
        r.typed = 0; r.kind = '0; r.ev_tot = '0; r.fe_tot = '0;
        if ($urandom_range(99) < 80) begin
          k = $urandom_range(39);
          r.id = key_pool[k];
          case ($urandom_range(19))
            0:       r.size = $urandom();
            1:       r.size = 32'hFFFF_FFFF;
            2:       r.size = 32'd0;
            3:       r.size = size_pool[k] + 1;
            default: r.size = size_pool[k];
          endcase
        end else begin
          r.id = $urandom();
          r.size = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(0, 1500);
        end
        send_access(r);
        sent++;
      end
    end
    in_ch.valid <= 1'b0;
    wait (pending_beats.size() == 0);
    repeat (4 * PASS_CYC) @(posedge clk);
    $display("tb: %0d accesses, %0d result beats checked (%0d evictions) over 6 budgets",
             directed.size() + sent, beats_seen, evicts_seen);
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end
endmodule

>>> size_budget_lru_cache_unit.f
sv/sblc_pkg.sv
sv/sblc_if.sv
sv/sblc_ram.sv
sv/sblc_datapath.sv
sv/sblc_ctrl.sv
sv/size_budget_lru_cache_unit.sv
tb/tb.sv
